// ----- hdl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the classifier RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
`define ASSERT_ALWAYS(name, clk, rstn, expr) \
    name: assert property (@(posedge clk) disable iff (!rstn) (expr)) \
        else $error("assertion failed");
`define ASSERT_IMPLIES(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ASSERT_NEXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_ALWAYS(name, clk, rstn, expr)
`define ASSERT_IMPLIES(name, clk, rstn, ante, cons)
`define ASSERT_NEXT(name, clk, rstn, ante, cons)
`endif

`endif

// ----- hdl/pcc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Polygon cluster classifier package
// Command codes, polygon header type and sequencer states.
// ----------------------------------------------------------------------------
package pcc_pkg;

    localparam int FUNC_W     = 3;
    localparam int DIM_W      = 4;
    localparam int CNT_W      = 6;
    localparam int IN_COORD_W = 16;

    typedef enum logic [FUNC_W-1:0] {
        FN_HEADER   = 3'd0,
        FN_VERTEX   = 3'd1,
        FN_FEATURE  = 3'd2,
        FN_CLASSIFY = 3'd3,
        FN_CLEAR    = 3'd4
    } func_t;

    typedef struct packed {
        logic             excl;
        logic [DIM_W-1:0] dim_a;
        logic [DIM_W-1:0] dim_b;
        logic [CNT_W-1:0] count;
    } poly_hdr_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_O_CHK,
        ST_O_RD0,
        ST_O_RD1,
        ST_O_RD2,
        ST_O_RD3,
        ST_O_EVAL,
        ST_O_FIN,
        ST_C_HDR,
        ST_C_FA,
        ST_C_FB,
        ST_C_P0A,
        ST_C_P0D,
        ST_E_ADDR,
        ST_E_DATA,
        ST_E_CHK,
        ST_M1,
        ST_M2,
        ST_M3,
        ST_E_EVAL,
        ST_CMP1,
        ST_CMP2,
        ST_CMP3,
        ST_CMP4,
        ST_CMP5,
        ST_CMP6,
        ST_E_NEXT,
        ST_C_POLY,
        ST_C_DONE
    } state_t;

endpackage

// ----- hdl/polygon_cluster_classifier.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Polygon cluster classifier
// Point-in-polygon test of a spike feature vector against a cluster of
// inclusive and exclusive 2-D polygons, run on one shared multiplier.
// ----------------------------------------------------------------------------
// Channel   Dir  Signals                          Word
// s_axis    in   tvalid tready tdata[79:0] tuser  command: header, vertex,
//                                                 feature, classify, clear
// m_axis    out  tvalid tready tdata[7:0]         classify result
//
// Header, feature and clear words are handled on acceptance; a vertex word
// that closes a polygon also starts an orientation check of its vertices.
// A classify walks every slot; a disabled slot or a polygon under three
// vertices contains nothing, and for each other polygon it tests the
// straddling edges and runs distance compares on the single multiplier that
// serves every cross product. The input is not ready while a word is being
// worked on, and a finished classify also waits while the previous result is
// still held. A result waits in the output register while new words are
// accepted. Reset clears headers and orientation flags; the vertex and
// feature memories hold no reset.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module polygon_cluster_classifier
    import pcc_pkg::*;
#(
    parameter int MAX_POLYGONS = 8,
    parameter int MAX_VERTICES = 32,
    parameter int NUM_FEATURES = 16,
    parameter int COORD_WIDTH  = 16
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    // slot[2:0], exclusive[3], dim_a[7:4], dim_b[11:8], vertex_count[17:12],
    // vertex_index[22:18], coord_a[38:23], coord_b[54:39],
    // feature_index[58:55], feature_value[74:59], zero[79:75]
    input  logic [79:0]       s_axis_tdata,
    // func[2:0]
    input  logic [FUNC_W-1:0] s_axis_tuser,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    // in_cluster[0], cluster_empty[1], zero[7:2]
    output logic [7:0]        m_axis_tdata
);

    localparam int SW     = (MAX_POLYGONS > 1) ? $clog2(MAX_POLYGONS) : 1;
    localparam int VDEPTH = MAX_POLYGONS * MAX_VERTICES;
    localparam int VA_W   = $clog2(VDEPTH);
    localparam int FW     = $clog2(NUM_FEATURES);
    localparam int MUL_W  = COORD_WIDTH + 3;
    localparam int ACC_W  = 3 * COORD_WIDTH + 6;
    localparam int NUM_W  = 2 * COORD_WIDTH + 3;
    localparam int DEN_W  = COORD_WIDTH + 1;
    localparam int SH     = COORD_WIDTH + 2;

    logic [2:0]                    slot_in;
    logic                          excl_in;
    logic [DIM_W-1:0]              dim_a_in;
    logic [DIM_W-1:0]              dim_b_in;
    logic [CNT_W-1:0]              vcount_in;
    logic [4:0]                    vindex_in;
    logic signed [IN_COORD_W-1:0]  coord_a_in;
    logic signed [IN_COORD_W-1:0]  coord_b_in;
    logic [DIM_W-1:0]              findex_in;
    logic signed [IN_COORD_W-1:0]  fvalue_in;

    assign slot_in    = s_axis_tdata[2:0];
    assign excl_in    = s_axis_tdata[3];
    assign dim_a_in   = s_axis_tdata[7:4];
    assign dim_b_in   = s_axis_tdata[11:8];
    assign vcount_in  = s_axis_tdata[17:12];
    assign vindex_in  = s_axis_tdata[22:18];
    assign coord_a_in = s_axis_tdata[38:23];
    assign coord_b_in = s_axis_tdata[54:39];
    assign findex_in  = s_axis_tdata[58:55];
    assign fvalue_in  = s_axis_tdata[74:59];

    state_t    state_reg, state_next;
    poly_hdr_t hdr_reg [MAX_POLYGONS];
    poly_hdr_t hdr_next [MAX_POLYGONS];
    logic      cw_reg [MAX_POLYGONS];
    logic      cw_next [MAX_POLYGONS];

    logic             m_valid_reg, m_valid_next;
    logic             in_cluster_reg, in_cluster_next;
    logic             empty_reg, empty_next;
    logic [SW-1:0]    poly_reg, poly_next;
    logic [CNT_W-1:0] n_reg, n_next;
    logic [CNT_W-1:0] c_reg, c_next;
    logic [CNT_W-1:0] j_reg, j_next;
    logic [CNT_W-1:0] nright_reg, nright_next;
    logic             ori_reg, ori_next;
    logic             cw_cur_reg, cw_cur_next;
    logic             excl_cur_reg, excl_cur_next;
    logic             have_reg, have_next;
    logic             inc_reg, inc_next;
    logic             exc_reg, exc_next;
    logic             anyinc_reg, anyinc_next;

    logic signed [COORD_WIDTH-1:0] pa_reg, pa_next, pb_reg, pb_next;
    logic signed [COORD_WIDTH-1:0] qa_reg, qa_next, qb_reg, qb_next;
    logic signed [COORD_WIDTH-1:0] ta_reg, ta_next, tb_reg, tb_next;
    logic signed [ACC_W-1:0]       acc_reg, acc_next;
    logic signed [2*MUL_W-1:0]     prod_reg;
    logic [NUM_W-1:0]              num_reg, num_next;
    logic [DEN_W-1:0]              den_reg, den_next;
    logic                          cur_right_reg, cur_right_next;
    logic [NUM_W-1:0]              bnum_reg, bnum_next;
    logic [DEN_W-1:0]              bden_reg, bden_next;
    logic                          bright_reg, bright_next;

    logic [2*COORD_WIDTH-1:0] vertex_mem [VDEPTH];
    logic signed [COORD_WIDTH-1:0] feature_mem [NUM_FEATURES];
    logic [2*COORD_WIDTH-1:0]      vrd_reg;
    logic signed [COORD_WIDTH-1:0] frd_reg;
    logic                          fok_reg;

    logic                          accept;
    logic [SW-1:0]                 slot_idx;
    logic                          slot_ok;
    logic                          idx_ok;
    logic [SW-1:0]                 hdr_idx;
    poly_hdr_t                     hdr_rd;
    logic                          cw_rd;
    logic                          vwe;
    logic [VA_W-1:0]               vwaddr;
    logic [2*COORD_WIDTH-1:0]      vwdata;
    logic                          fwe;
    logic [CNT_W-1:0]              vidx;
    logic [VA_W-1:0]               vaddr;
    logic [DIM_W-1:0]              faddr;
    logic signed [COORD_WIDTH-1:0] fdata;
    logic [CNT_W-1:0]              walk_idx;
    logic signed [MUL_W-1:0]       mul_a, mul_b;
    logic signed [MUL_W-1:0]       dy;
    logic signed [MUL_W-1:0]       dy_abs;
    logic signed [ACC_W-1:0]       num_s;
    logic                          straddle;
    logic [CNT_W:0]                c_ext, n_ext, nright_ext;

    assign accept        = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {6'b0, empty_reg, in_cluster_reg};

    assign slot_idx = SW'(slot_in);
    assign slot_ok  = (32'(slot_in) < MAX_POLYGONS);
    assign idx_ok   = (32'(vindex_in) < MAX_VERTICES);
    assign hdr_idx  = (state_reg == ST_IDLE) ? slot_idx : poly_reg;
    assign hdr_rd   = hdr_reg[hdr_idx];
    assign cw_rd    = cw_reg[hdr_idx];

    assign vwe    = accept && (func_t'(s_axis_tuser) == FN_VERTEX) && slot_ok && idx_ok;
    assign vwaddr = VA_W'(slot_idx) * VA_W'(MAX_VERTICES) + VA_W'(vindex_in);
    assign vwdata = {COORD_WIDTH'(coord_b_in), COORD_WIDTH'(coord_a_in)};
    assign fwe    = accept && (func_t'(s_axis_tuser) == FN_FEATURE)
                    && (32'(findex_in) < NUM_FEATURES);
    assign vaddr  = VA_W'(poly_reg) * VA_W'(MAX_VERTICES) + VA_W'(vidx);
    assign fdata  = fok_reg ? frd_reg : '0;

    assign walk_idx = cw_cur_reg ? ((j_reg == n_reg) ? '0 : j_reg) : (n_reg - j_reg);
    assign dy       = MUL_W'(qb_reg) - MUL_W'(pb_reg);
    assign dy_abs   = dy[MUL_W-1] ? -dy : dy;
    assign num_s    = dy[MUL_W-1] ? -acc_reg : acc_reg;
    assign straddle = (qb_reg > tb_reg && pb_reg < tb_reg)
                      || (qb_reg < tb_reg && pb_reg > tb_reg);
    assign c_ext      = {1'b0, c_reg};
    assign n_ext      = {1'b0, n_reg};
    assign nright_ext = {1'b0, nright_reg};

    always_comb
    begin
        state_next      = state_reg;
        hdr_next        = hdr_reg;
        cw_next         = cw_reg;
        m_valid_next    = m_valid_reg;
        in_cluster_next = in_cluster_reg;
        empty_next      = empty_reg;
        poly_next       = poly_reg;
        n_next          = n_reg;
        c_next          = c_reg;
        j_next          = j_reg;
        nright_next     = nright_reg;
        ori_next        = ori_reg;
        cw_cur_next     = cw_cur_reg;
        excl_cur_next   = excl_cur_reg;
        have_next       = have_reg;
        inc_next        = inc_reg;
        exc_next        = exc_reg;
        anyinc_next     = anyinc_reg;
        pa_next         = pa_reg;
        pb_next         = pb_reg;
        qa_next         = qa_reg;
        qb_next         = qb_reg;
        ta_next         = ta_reg;
        tb_next         = tb_reg;
        acc_next        = acc_reg;
        num_next        = num_reg;
        den_next        = den_reg;
        cur_right_next  = cur_right_reg;
        bnum_next       = bnum_reg;
        bden_next       = bden_reg;
        bright_next     = bright_reg;
        mul_a           = '0;
        mul_b           = '0;
        vidx            = '0;
        faddr           = hdr_rd.dim_a;

        if (m_valid_reg && m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (func_t'(s_axis_tuser))
                        FN_HEADER:
                        begin
                            if (slot_ok)
                            begin
                                hdr_next[slot_idx].excl  = excl_in;
                                hdr_next[slot_idx].dim_a = dim_a_in;
                                hdr_next[slot_idx].dim_b = dim_b_in;
                                hdr_next[slot_idx].count =
                                    (32'(vcount_in) > MAX_VERTICES) ?
                                    CNT_W'(MAX_VERTICES) : vcount_in;
                                cw_next[slot_idx] = 1'b0;
                            end
                        end
                        FN_VERTEX:
                        begin
                            if (slot_ok && idx_ok && hdr_rd.count != '0
                                && CNT_W'(vindex_in) == hdr_rd.count - CNT_W'(1))
                            begin
                                poly_next   = slot_idx;
                                n_next      = hdr_rd.count;
                                c_next      = '0;
                                nright_next = '0;
                                ori_next    = 1'b1;
                                state_next  = ST_O_CHK;
                            end
                        end
                        FN_CLASSIFY:
                        begin
                            poly_next   = '0;
                            inc_next    = 1'b0;
                            exc_next    = 1'b0;
                            anyinc_next = 1'b0;
                            ori_next    = 1'b0;
                            state_next  = ST_C_HDR;
                        end
                        FN_CLEAR:
                        begin
                            for (int i = 0; i < MAX_POLYGONS; i++)
                            begin
                                hdr_next[i] = '0;
                                cw_next[i]  = 1'b0;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_O_CHK:
            begin
                if (c_ext + (CNT_W+1)'(2) > n_ext)
                    state_next = ST_O_FIN;
                else
                    state_next = ST_O_RD0;
            end
            ST_O_RD0:
            begin
                vidx       = c_reg;
                state_next = ST_O_RD1;
            end
            ST_O_RD1:
            begin
                pa_next    = vrd_reg[COORD_WIDTH-1:0];
                pb_next    = vrd_reg[2*COORD_WIDTH-1:COORD_WIDTH];
                vidx       = c_reg + CNT_W'(1);
                state_next = ST_O_RD2;
            end
            ST_O_RD2:
            begin
                qa_next    = vrd_reg[COORD_WIDTH-1:0];
                qb_next    = vrd_reg[2*COORD_WIDTH-1:COORD_WIDTH];
                vidx       = (c_reg + CNT_W'(2) == n_reg) ? '0 : c_reg + CNT_W'(2);
                state_next = ST_O_RD3;
            end
            ST_O_RD3:
            begin
                ta_next    = vrd_reg[COORD_WIDTH-1:0];
                tb_next    = vrd_reg[2*COORD_WIDTH-1:COORD_WIDTH];
                state_next = ST_M1;
            end
            ST_M1:
            begin
                mul_a      = MUL_W'(ta_reg) - MUL_W'(pa_reg);
                mul_b      = dy;
                state_next = ST_M2;
            end
            ST_M2:
            begin
                acc_next   = ACC_W'(prod_reg);
                mul_a      = MUL_W'(tb_reg) - MUL_W'(pb_reg);
                mul_b      = MUL_W'(qa_reg) - MUL_W'(pa_reg);
                state_next = ST_M3;
            end
            ST_M3:
            begin
                acc_next   = acc_reg - ACC_W'(prod_reg);
                state_next = ori_reg ? ST_O_EVAL : ST_E_EVAL;
            end
            ST_O_EVAL:
            begin
                if (acc_reg < 0)
                    nright_next = nright_reg + CNT_W'(1);
                c_next     = c_reg + CNT_W'(1);
                state_next = ST_O_CHK;
            end
            ST_O_FIN:
            begin
                cw_next[poly_reg] = (nright_ext >= ((n_ext + (CNT_W+1)'(1)) >> 1));
                state_next        = ST_IDLE;
            end
            ST_C_HDR:
            begin
                n_next        = hdr_rd.count;
                cw_cur_next   = cw_rd;
                excl_cur_next = hdr_rd.excl;
                have_next     = 1'b0;
                if (hdr_rd.count == '0)
                begin
                    state_next = ST_C_POLY;
                end
                else
                begin
                    if (!hdr_rd.excl)
                        anyinc_next = 1'b1;
                    state_next = ST_C_FA;
                end
            end
            ST_C_FA:
            begin
                faddr      = hdr_rd.dim_b;
                ta_next    = fdata;
                state_next = ST_C_FB;
            end
            ST_C_FB:
            begin
                tb_next = fdata;
                if (n_reg < CNT_W'(3))
                    state_next = ST_C_POLY;
                else
                    state_next = ST_C_P0A;
            end
            ST_C_P0A:
            begin
                vidx       = '0;
                state_next = ST_C_P0D;
            end
            ST_C_P0D:
            begin
                qa_next    = vrd_reg[COORD_WIDTH-1:0];
                qb_next    = vrd_reg[2*COORD_WIDTH-1:COORD_WIDTH];
                j_next     = CNT_W'(1);
                state_next = ST_E_ADDR;
            end
            ST_E_ADDR:
            begin
                pa_next    = qa_reg;
                pb_next    = qb_reg;
                vidx       = walk_idx;
                state_next = ST_E_DATA;
            end
            ST_E_DATA:
            begin
                qa_next    = vrd_reg[COORD_WIDTH-1:0];
                qb_next    = vrd_reg[2*COORD_WIDTH-1:COORD_WIDTH];
                state_next = ST_E_CHK;
            end
            ST_E_CHK:
            begin
                state_next = straddle ? ST_M1 : ST_E_NEXT;
            end
            ST_E_EVAL:
            begin
                state_next = ST_E_NEXT;
                if (num_s > 0)
                begin
                    if (!have_reg)
                    begin
                        have_next   = 1'b1;
                        bnum_next   = NUM_W'(num_s);
                        bden_next   = DEN_W'(dy_abs);
                        bright_next = (acc_reg < 0);
                    end
                    else
                    begin
                        num_next       = NUM_W'(num_s);
                        den_next       = DEN_W'(dy_abs);
                        cur_right_next = (acc_reg < 0);
                        state_next     = ST_CMP1;
                    end
                end
            end
            ST_CMP1:
            begin
                mul_a      = $signed(MUL_W'(num_reg[SH-1:0]));
                mul_b      = $signed(MUL_W'(bden_reg));
                state_next = ST_CMP2;
            end
            ST_CMP2:
            begin
                acc_next   = ACC_W'(prod_reg);
                mul_a      = $signed(MUL_W'(num_reg[NUM_W-1:SH]));
                mul_b      = $signed(MUL_W'(bden_reg));
                state_next = ST_CMP3;
            end
            ST_CMP3:
            begin
                acc_next   = acc_reg + (ACC_W'(prod_reg) <<< SH);
                mul_a      = $signed(MUL_W'(bnum_reg[SH-1:0]));
                mul_b      = $signed(MUL_W'(den_reg));
                state_next = ST_CMP4;
            end
            ST_CMP4:
            begin
                acc_next   = acc_reg - ACC_W'(prod_reg);
                mul_a      = $signed(MUL_W'(bnum_reg[NUM_W-1:SH]));
                mul_b      = $signed(MUL_W'(den_reg));
                state_next = ST_CMP5;
            end
            ST_CMP5:
            begin
                acc_next   = acc_reg - (ACC_W'(prod_reg) <<< SH);
                state_next = ST_CMP6;
            end
            ST_CMP6:
            begin
                if (acc_reg < 0)
                begin
                    bnum_next   = num_reg;
                    bden_next   = den_reg;
                    bright_next = cur_right_reg;
                end
                state_next = ST_E_NEXT;
            end
            ST_E_NEXT:
            begin
                if (j_reg == n_reg)
                begin
                    state_next = ST_C_POLY;
                end
                else
                begin
                    j_next     = j_reg + CNT_W'(1);
                    state_next = ST_E_ADDR;
                end
            end
            ST_C_POLY:
            begin
                if (excl_cur_reg)
                    exc_next = exc_reg || (have_reg && bright_reg);
                else
                    inc_next = inc_reg || (have_reg && bright_reg);
                if (32'(poly_reg) == MAX_POLYGONS - 1)
                begin
                    state_next = ST_C_DONE;
                end
                else
                begin
                    poly_next  = poly_reg + SW'(1);
                    state_next = ST_C_HDR;
                end
            end
            ST_C_DONE:
            begin
                if (!m_valid_reg || m_axis_tready)
                begin
                    in_cluster_next = inc_reg && !exc_reg;
                    empty_next      = !anyinc_reg;
                    m_valid_next    = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            m_valid_reg  <= 1'b0;
            poly_reg     <= '0;
            n_reg        <= '0;
            c_reg        <= '0;
            j_reg        <= '0;
            nright_reg   <= '0;
            ori_reg      <= 1'b0;
            cw_cur_reg   <= 1'b0;
            excl_cur_reg <= 1'b0;
            have_reg     <= 1'b0;
            inc_reg      <= 1'b0;
            exc_reg      <= 1'b0;
            anyinc_reg   <= 1'b0;
            for (int i = 0; i < MAX_POLYGONS; i++)
            begin
                hdr_reg[i] <= '0;
                cw_reg[i]  <= 1'b0;
            end
        end
        else
        begin
            state_reg    <= state_next;
            m_valid_reg  <= m_valid_next;
            poly_reg     <= poly_next;
            n_reg        <= n_next;
            c_reg        <= c_next;
            j_reg        <= j_next;
            nright_reg   <= nright_next;
            ori_reg      <= ori_next;
            cw_cur_reg   <= cw_cur_next;
            excl_cur_reg <= excl_cur_next;
            have_reg     <= have_next;
            inc_reg      <= inc_next;
            exc_reg      <= exc_next;
            anyinc_reg   <= anyinc_next;
            hdr_reg      <= hdr_next;
            cw_reg       <= cw_next;
        end
    end

    always_ff @(posedge clk)
    begin
        in_cluster_reg <= in_cluster_next;
        empty_reg      <= empty_next;
        pa_reg         <= pa_next;
        pb_reg         <= pb_next;
        qa_reg         <= qa_next;
        qb_reg         <= qb_next;
        ta_reg         <= ta_next;
        tb_reg         <= tb_next;
        acc_reg        <= acc_next;
        prod_reg       <= mul_a * mul_b;
        num_reg        <= num_next;
        den_reg        <= den_next;
        cur_right_reg  <= cur_right_next;
        bnum_reg       <= bnum_next;
        bden_reg       <= bden_next;
        bright_reg     <= bright_next;
    end

    always_ff @(posedge clk)
    begin
        if (vwe)
            vertex_mem[vwaddr] <= vwdata;
        vrd_reg <= vertex_mem[vaddr];
    end

    always_ff @(posedge clk)
    begin
        if (fwe)
            feature_mem[FW'(findex_in)] <= COORD_WIDTH'(fvalue_in);
        frd_reg <= feature_mem[FW'(faddr)];
        fok_reg <= (32'(faddr) < NUM_FEATURES);
    end

    `ASSERT_IMPLIES(a_best_den_nonzero, clk, rst_n, have_reg, bden_reg != '0)
    `ASSERT_NEXT(a_result_waits, clk, rst_n,
        state_reg == ST_C_DONE && m_valid_reg && !m_axis_tready,
        state_reg == ST_C_DONE && m_valid_reg)
    `ASSERT_IMPLIES(a_triple_in_range, clk, rst_n, state_reg == ST_O_RD0,
        c_ext + (CNT_W+1)'(2) <= n_ext)
    `ASSERT_IMPLIES(a_edge_in_range, clk, rst_n, state_reg == ST_E_ADDR,
        j_reg != '0 && j_reg <= n_reg)
    `ASSERT_IMPLIES(a_right_count_bound, clk, rst_n, state_reg == ST_O_FIN,
        nright_reg <= n_reg)

endmodule

// ----- test/classifier_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Polygon cluster classifier checker
// Watches both stream channels, keeps its own copy of the polygon headers,
// vertices, orientation flags and features, predicts each classify answer
// and compares every result word with the oldest prediction.
// ----------------------------------------------------------------------------
module classifier_checker
    import pcc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [79:0] s_axis_tdata,
    input  logic [2:0]  s_axis_tuser,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [7:0]  m_axis_tdata,
    output int          fail_count,
    output int          pending
);

    typedef struct packed {
        logic in_cluster;
        logic cluster_empty;
    } verdict_t;

    typedef struct {
        longint a;
        longint b;
    } point_t;

    poly_hdr_t          hdr_q [8];
    logic               cw_q [8];
    logic signed [15:0] va_q [8][32];
    logic signed [15:0] vb_q [8][32];
    logic signed [15:0] feat_q [16];
    verdict_t           verdicts_due[$];
    int                 fails = 0;
    int                 due_count = 0;

    assign fail_count = fails;
    assign pending    = due_count;

    task automatic report(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        fails++;
    endtask

    function automatic logic on_right(point_t p, point_t q, point_t t);
        longint s;
        s = (t.a - p.a) * (q.b - p.b) - (t.b - p.b) * (q.a - p.a);
        return s < 0;
    endfunction

    function automatic point_t vertex_at(int s, int k);
        point_t r;
        r.a = va_q[s][k];
        r.b = vb_q[s][k];
        return r;
    endfunction

    function automatic point_t walk_vertex(int s, int n, int j);
        int k;
        if (cw_q[s])
            k = (j == n) ? 0 : j;
        else
            k = (j == 0) ? 0 : n - j;
        return vertex_at(s, k);
    endfunction

    function automatic void orient(int s, int n);
        int nright;
        int i1;
        int i2;
        nright = 0;
        for (int c = 0; c + 2 <= n; c++)
        begin
            i1 = (c + 1) % n;
            i2 = (c + 2) % n;
            if (on_right(vertex_at(s, c), vertex_at(s, i1), vertex_at(s, i2)))
                nright++;
        end
        cw_q[s] = (nright >= (n + 1) / 2);
    endfunction

    function automatic logic contains(int s, point_t pt);
        int     n;
        logic   have;
        longint bnum;
        longint bden;
        longint num;
        longint den;
        longint dy;
        point_t p;
        point_t q;
        point_t bp;
        point_t bq;
        n = int'(hdr_q[s].count);
        have = 1'b0;
        bnum = 0;
        bden = 1;
        bp = pt;
        bq = pt;
        if (n < 3)
            return 1'b0;
        for (int j = 1; j <= n; j++)
        begin
            p = walk_vertex(s, n, j - 1);
            q = walk_vertex(s, n, j);
            if (!((q.b > pt.b && p.b < pt.b) || (q.b < pt.b && p.b > pt.b)))
                continue;
            dy = q.b - p.b;
            num = (pt.a - p.a) * dy - (q.a - p.a) * (pt.b - p.b);
            den = dy;
            if (dy < 0)
            begin
                num = -num;
                den = -dy;
            end
            if (num <= 0)
                continue;
            if (!have || num * bden < bnum * den)
            begin
                have = 1'b1;
                bnum = num;
                bden = den;
                bp = p;
                bq = q;
            end
        end
        return have && on_right(bp, bq, pt);
    endfunction

    function automatic verdict_t classify();
        verdict_t v;
        logic     inc;
        logic     exc;
        logic     any_inc;
        point_t   pt;
        inc = 1'b0;
        exc = 1'b0;
        any_inc = 1'b0;
        for (int s = 0; s < 8; s++)
        begin
            if (hdr_q[s].count == 0)
                continue;
            pt.a = feat_q[hdr_q[s].dim_a];
            pt.b = feat_q[hdr_q[s].dim_b];
            if (hdr_q[s].excl)
            begin
                if (contains(s, pt))
                    exc = 1'b1;
            end
            else
            begin
                any_inc = 1'b1;
                if (contains(s, pt))
                    inc = 1'b1;
            end
        end
        v.in_cluster = inc && !exc;
        v.cluster_empty = !any_inc;
        return v;
    endfunction

    task automatic apply_word(input logic [2:0] f, input logic [79:0] d);
        int slot;
        int idx;
        int cnt;
        slot = int'(d[2:0]);
        idx  = int'(d[22:18]);
        case (f)
            FN_HEADER:
            begin
                cnt = int'(d[17:12]);
                if (cnt > 32)
                    cnt = 32;
                hdr_q[slot].excl  = d[3];
                hdr_q[slot].dim_a = d[7:4];
                hdr_q[slot].dim_b = d[11:8];
                hdr_q[slot].count = 6'(cnt);
                cw_q[slot] = 1'b0;
            end
            FN_VERTEX:
            begin
                va_q[slot][idx] = d[38:23];
                vb_q[slot][idx] = d[54:39];
                cnt = int'(hdr_q[slot].count);
                if (cnt != 0 && idx == cnt - 1)
                    orient(slot, cnt);
            end
            FN_FEATURE:
                feat_q[d[58:55]] = d[74:59];
            FN_CLASSIFY:
                verdicts_due.insert(verdicts_due.size(), classify());
            FN_CLEAR:
                for (int s = 0; s < 8; s++)
                begin
                    hdr_q[s] = '0;
                    cw_q[s]  = 1'b0;
                end
            default:
                ;
        endcase
    endtask

    always @(posedge clk)
    begin
        verdict_t want;
        if (!rst_n)
        begin
            for (int s = 0; s < 8; s++)
            begin
                hdr_q[s] = '0;
                cw_q[s]  = 1'b0;
            end
            verdicts_due.delete();
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (verdicts_due.size() == 0)
                    report($sformatf("result word %h with nothing expected", m_axis_tdata));
                else
                begin
                    want = verdicts_due.pop_front();
                    if (m_axis_tdata[0] !== want.in_cluster)
                        report($sformatf("in_cluster %b, expected %b",
                                         m_axis_tdata[0], want.in_cluster));
                    if (m_axis_tdata[1] !== want.cluster_empty)
                        report($sformatf("cluster_empty %b, expected %b",
                                         m_axis_tdata[1], want.cluster_empty));
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                apply_word(s_axis_tuser, s_axis_tdata);
        end
        due_count = verdicts_due.size();
    end

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Polygon cluster classifier testbench
// Loads polygons and features, classifies spike vectors under several
// idle and stall patterns, and gives the verdict from the checker's count.
// ----------------------------------------------------------------------------
module testbench
    import pcc_pkg::*;
();

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [79:0] s_axis_tdata = '0;
    logic [2:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;
    int          fail_count;
    int          pending;
    int          idle_pct = 0;
    int          stall_pct = 0;
    int          quiet_cycles = 0;
    int          sent = 0;
    logic [31:0] written [8];

    always #10 clk = ~clk;

    polygon_cluster_classifier DUT (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    classifier_checker scoreboard (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .fail_count(fail_count), .pending(pending)
    );

    always @(posedge clk)
        m_axis_tready <= ($urandom_range(99) >= stall_pct);

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= 40000)
        begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic send(input logic [2:0] f, input logic [79:0] d);
        if ($urandom_range(99) < idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= f;
        s_axis_tdata  <= d;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sent++;
    endtask

    function automatic logic [15:0] pick_coord(int scale);
        case (scale)
            0: return 16'($signed($urandom_range(16)) - 8);
            1: return 16'($signed($urandom_range(2000)) - 1000);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [79:0] header_word(int slot, logic excl, int n);
        logic [79:0] d;
        d = '0;
        d[2:0] = 3'(slot);
        d[3] = excl;
        d[7:4] = 4'($urandom_range(15));
        d[11:8] = 4'($urandom_range(15));
        d[17:12] = 6'(n);
        return d;
    endfunction

    task automatic put_vertex(int slot, int idx, int scale);
        logic [79:0] d;
        d = '0;
        d[2:0] = 3'(slot);
        d[22:18] = 5'(idx);
        d[38:23] = pick_coord(scale);
        d[54:39] = pick_coord(scale);
        written[slot][idx] = 1'b1;
        send(FN_VERTEX, d);
    endtask

    task automatic put_feature(int idx, logic [15:0] v);
        logic [79:0] d;
        d = '0;
        d[58:55] = 4'(idx);
        d[74:59] = v;
        send(FN_FEATURE, d);
    endtask

    task automatic load_polygon(int slot, logic broken);
        int n_raw;
        int n;
        int scale;
        int order [32];
        int k;
        int t;
        n_raw = ($urandom_range(19) == 0) ? $urandom_range(63) : $urandom_range(3, 8);
        n = (n_raw > 32) ? 32 : n_raw;
        scale = $urandom_range(2);
        send(FN_HEADER, header_word(slot, $urandom_range(9) < 3, n_raw));
        if (broken)
        begin
            for (int i = 0; i < n - 2; i++)
                put_vertex(slot, i, scale);
            send(FN_HEADER, header_word(slot, 1'b0, 0));
        end
        else if (n > 0)
        begin
            for (int i = 0; i < n - 1; i++)
                order[i] = i;
            for (int i = n - 2; i > 0; i--)
            begin
                k = $urandom_range(i);
                t = order[i];
                order[i] = order[k];
                order[k] = t;
            end
            for (int i = 0; i < n - 1; i++)
                put_vertex(slot, order[i], scale);
            put_vertex(slot, n - 1, scale);
        end
    endtask

    task automatic random_word();
        int pick;
        int slot;
        int n;
        pick = $urandom_range(99);
        slot = $urandom_range(7);
        if (pick < 28)
            load_polygon(slot, 1'b0);
        else if (pick < 34)
            load_polygon(slot, 1'b1);
        else if (pick < 54)
            put_feature($urandom_range(15), pick_coord($urandom_range(2)));
        else if (pick < 86)
            send(FN_CLASSIFY, 80'($urandom));
        else if (pick < 90)
            send(FN_CLEAR, '0);
        else if (pick < 94)
        begin
            n = $urandom_range(63);
            if (!(&(written[slot] | ~((33'd1 << ((n > 32) ? 32 : n)) - 1))))
                n = 0;
            send(FN_HEADER, header_word(slot, $urandom_range(1), n));
        end
        else if (pick < 98)
            put_vertex(slot, $urandom_range(31), $urandom_range(2));
        else
            send(3'(FN_CLEAR) + 3'($urandom_range(1, 3)), 80'($urandom));
    endtask

    initial
    begin
        for (int s = 0; s < 8; s++)
            written[s] = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send(FN_CLASSIFY, '0);
        for (int i = 0; i < 16; i++)
            put_feature(i, (i == 0) ? 16'h8000 : (i == 1) ? 16'h7fff : 16'(i - 8));
        send(FN_HEADER, header_word(7, 1'b0, 3));
        put_vertex(7, 0, 2);
        put_vertex(7, 1, 2);
        put_vertex(7, 2, 2);
        send(FN_CLASSIFY, '0);
        send(FN_CLEAR, '0);
        send(3'(FN_CLEAR) + 3'd1, '1);
        send(3'(FN_CLEAR) + 3'd3, '0);

        for (int phase = 0; phase < 4; phase++)
        begin
            idle_pct  = (phase == 1 || phase == 3) ? ((phase == 1) ? 55 : 13) : 0;
            stall_pct = (phase == 2 || phase == 3) ? ((phase == 2) ? 55 : 13) : 0;
            while (sent < 25 + (phase + 1) * 490)
                random_word();
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
            while (pending != 0)
                @(posedge clk);
        end

        repeat (400) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
